@@ hw/rtl/pdb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared widths, pipeline payload types and arithmetic steps for the point
// distance and bearing pipeline.
// ----------------------------------------------------------------------------
package pdb_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int DIFF_W            = COORD_WIDTH + 1;
    localparam int MAG_W             = DIFF_W;
    localparam int SQ_W              = 2 * MAG_W;
    localparam int ROOT_W            = MAG_W;
    localparam int REM_W             = ROOT_W + 3;
    localparam int NORM_MSB          = 30;
    localparam int MSB_W             = $clog2(MAG_W);
    localparam int SHIFT_W           = $clog2(NORM_MSB + 1);
    localparam int XY_W              = NORM_MSB + 4;
    localparam int Z_W               = 34;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_PER_STAGE  = 2;
    localparam int SQRT_PER_STAGE    = 3;
    localparam int CORE_STAGES       = 8;
    localparam int ACC_FRAC          = 24;
    localparam int ANGLE_FRAC_BITS   = 8;
    localparam int ROUND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int B_W               = Z_W + 2;
    localparam int OUT_W             = 17;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic dx_zero;
        logic dy_zero;
    } pdb_flags_t;

    typedef struct packed {
        pdb_flags_t       flags;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } pdb_diff_t;

    typedef struct packed {
        pdb_flags_t             flags;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
    } pdb_work_t;

    // atan(2^-i) in degrees with 24 fractional bits.
    function automatic logic signed [Z_W-1:0] atan_deg(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(754974720);
            1:       v = Z_W'(445687602);
            2:       v = Z_W'(235489089);
            3:       v = Z_W'(119537938);
            4:       v = Z_W'(60000934);
            5:       v = Z_W'(30029717);
            6:       v = Z_W'(15018523);
            7:       v = Z_W'(7509720);
            8:       v = Z_W'(3754917);
            9:       v = Z_W'(1877466);
            10:      v = Z_W'(938734);
            11:      v = Z_W'(469367);
            12:      v = Z_W'(234684);
            13:      v = Z_W'(117342);
            14:      v = Z_W'(58671);
            15:      v = Z_W'(29335);
            16:      v = Z_W'(14668);
            17:      v = Z_W'(7334);
            18:      v = Z_W'(3667);
            19:      v = Z_W'(1833);
            20:      v = Z_W'(917);
            21:      v = Z_W'(458);
            22:      v = Z_W'(229);
            23:      v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    // One vectoring rotation; i is a constant at every call site.
    function automatic pdb_work_t cordic_step(input pdb_work_t w, input int i);
        pdb_work_t r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        r  = w;
        xs = w.x >>> i;
        ys = w.y >>> i;
        if (!w.y[XY_W-1])
        begin
            r.x = w.x + ys;
            r.y = w.y - xs;
            r.z = w.z + atan_deg(i);
        end
        else
        begin
            r.x = w.x - ys;
            r.y = w.y + xs;
            r.z = w.z - atan_deg(i);
        end
        return r;
    endfunction

    // One restoring square root step on bit pair p of the radicand.
    function automatic pdb_work_t sqrt_step(input pdb_work_t w, input int p);
        pdb_work_t r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        r      = w;
        rem_sh = {w.rem[REM_W-3:0], w.rad[2*p +: 2]};
        trial  = REM_W'({w.root, 2'b01});
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {w.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {w.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/pdb_front.sv @@
// ----------------------------------------------------------------------------
// pdb_front
// Two register stages: coordinate differences and magnitudes, then the sum
// of squares and the normalization of the vector for the rotation stages.
// ----------------------------------------------------------------------------
module pdb_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_y,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pdb_pkg::pdb_work_t                    out_work
);
    import pdb_pkg::*;

    logic                    diff_valid_reg;
    pdb_diff_t               diff_reg;
    pdb_diff_t               diff_next;
    logic                    diff_ready;
    logic                    work_valid_reg;
    pdb_work_t               work_reg;
    pdb_work_t               work_next;
    logic                    work_ready;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [MAG_W-1:0]        mag_max;
    logic [MSB_W-1:0]        msb;
    logic [SHIFT_W-1:0]      shift;

    assign work_ready = !work_valid_reg || out_ready;
    assign diff_ready = !diff_valid_reg || work_ready;
    assign in_ready   = diff_ready;
    assign out_valid  = work_valid_reg;
    assign out_work   = work_reg;

    always_comb
    begin
        dx = DIFF_W'(ref_x) - DIFF_W'(target_x);
        dy = DIFF_W'(ref_y) - DIFF_W'(target_y);
        diff_next.flags.dx_neg  = dx[DIFF_W-1];
        diff_next.flags.dy_neg  = dy[DIFF_W-1];
        diff_next.flags.dx_zero = (dx == '0);
        diff_next.flags.dy_zero = (dy == '0);
        diff_next.ax = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        diff_next.ay = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    end

    // The larger magnitude is shifted so that its top bit lands on NORM_MSB.
    always_comb
    begin
        mag_max = (diff_reg.ax > diff_reg.ay) ? diff_reg.ax : diff_reg.ay;
        msb     = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_max[i])
            begin
                msb = MSB_W'(i);
            end
        end
        shift = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
        work_next.flags = diff_reg.flags;
        work_next.x     = XY_W'(diff_reg.ax) << shift;
        work_next.y     = XY_W'(diff_reg.ay) << shift;
        work_next.z     = '0;
        work_next.rad   = SQ_W'(diff_reg.ax * diff_reg.ax)
                        + SQ_W'(diff_reg.ay * diff_reg.ay);
        work_next.rem   = '0;
        work_next.root  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            work_valid_reg <= 1'b0;
        end
        else
        begin
            if (diff_ready)
            begin
                diff_valid_reg <= in_valid;
            end
            if (work_ready)
            begin
                work_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (diff_ready && in_valid)
        begin
            diff_reg <= diff_next;
        end
        if (work_ready && diff_valid_reg)
        begin
            work_reg <= work_next;
        end
    end

endmodule

@@ hw/rtl/pdb_core.sv @@
// ----------------------------------------------------------------------------
// pdb_core
// Chain of register stages; each does two CORDIC rotations and up to three
// square root steps side by side.
// ----------------------------------------------------------------------------
module pdb_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdb_pkg::pdb_work_t in_work,
    output logic               out_valid,
    input  logic               out_ready,
    output pdb_pkg::pdb_work_t out_work
);
    import pdb_pkg::*;

    pdb_work_t src_data  [CORE_STAGES+1];
    logic      src_valid [CORE_STAGES+1];
    logic      ready     [CORE_STAGES+1];

    assign src_data[0]          = in_work;
    assign src_valid[0]         = in_valid;
    assign ready[CORE_STAGES]   = out_ready;
    assign in_ready             = ready[0];
    assign out_valid            = src_valid[CORE_STAGES];
    assign out_work             = src_data[CORE_STAGES];

    for (genvar k = 0; k < CORE_STAGES; k++)
    begin : g_stage
        pdb_work_t stage_reg;
        pdb_work_t stage_next;
        logic      valid_reg;

        assign ready[k]         = !valid_reg || ready[k+1];
        assign src_data[k+1]    = stage_reg;
        assign src_valid[k+1]   = valid_reg;

        always_comb
        begin
            stage_next = src_data[k];
            for (int t = 0; t < CORDIC_PER_STAGE; t++)
            begin
                if (k * CORDIC_PER_STAGE + t < CORDIC_ITERATIONS)
                begin
                    stage_next = cordic_step(stage_next, k * CORDIC_PER_STAGE + t);
                end
            end
            for (int t = 0; t < SQRT_PER_STAGE; t++)
            begin
                if (k * SQRT_PER_STAGE + t < ROOT_W)
                begin
                    stage_next = sqrt_step(stage_next,
                                           ROOT_W - 1 - (k * SQRT_PER_STAGE + t));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (ready[k])
            begin
                valid_reg <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[k] && src_valid[k])
            begin
                stage_reg <= stage_next;
            end
        end
    end

endmodule

@@ hw/rtl/pdb_back.sv @@
// ----------------------------------------------------------------------------
// pdb_back
// Output register: quadrant correction, rounding of the bearing and the
// axis and coincident-point cases.
// ----------------------------------------------------------------------------
module pdb_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pdb_pkg::pdb_work_t             in_work,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pdb_pkg::OUT_W-1:0]      distance,
    output logic [pdb_pkg::OUT_W-1:0]      bearing,
    output logic                           angle_invalid
);
    import pdb_pkg::*;

    logic                  valid_reg;
    logic [OUT_W-1:0]      distance_reg;
    logic [OUT_W-1:0]      bearing_reg;
    logic                  invalid_reg;
    logic [OUT_W-1:0]      bearing_next;
    logic                  invalid_next;
    logic signed [B_W-1:0] angle;
    logic signed [B_W-1:0] b24;
    logic signed [B_W-1:0] rounded;

    assign in_ready      = !valid_reg || !out_stall;
    assign out_valid     = valid_reg;
    assign distance      = distance_reg;
    assign bearing       = bearing_reg;
    assign angle_invalid = invalid_reg;

    always_comb
    begin
        angle = B_W'(in_work.z);
        if (in_work.flags.dx_neg != in_work.flags.dy_neg)
        begin
            angle = -angle;
        end
        b24 = (B_W'(180) <<< ACC_FRAC) - angle;
        if (b24[B_W-1])
        begin
            b24 = '0;
        end
        rounded      = b24 + (B_W'(1) <<< (ROUND_SHIFT - 1));
        invalid_next = 1'b0;
        if (in_work.flags.dx_zero && in_work.flags.dy_zero)
        begin
            invalid_next = 1'b1;
            bearing_next = '0;
        end
        else if (in_work.flags.dx_zero)
        begin
            bearing_next = in_work.flags.dy_neg ? (OUT_W'(270) << ANGLE_FRAC_BITS)
                                                : (OUT_W'(90) << ANGLE_FRAC_BITS);
        end
        else if (in_work.flags.dy_zero)
        begin
            bearing_next = OUT_W'(180) << ANGLE_FRAC_BITS;
        end
        else
        begin
            bearing_next = rounded[ROUND_SHIFT +: OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            distance_reg <= in_work.root;
            bearing_reg  <= bearing_next;
            invalid_reg  <= invalid_next;
        end
    end

endmodule

@@ hw/rtl/point_distance_and_bearing.sv @@
// ----------------------------------------------------------------------------
// point_distance_and_bearing
// Distance and bearing from a reference point to a target point.
// ----------------------------------------------------------------------------
// Usage: a request carries ref_x, ref_y, target_x and target_y (signed, four
// fractional bits). It is taken at a clock edge where in_valid is high and
// in_stall is low. Each request gives exactly one result on distance,
// bearing and angle_invalid, taken where out_valid is high and out_stall
// is low.
// A request passes through two front stages (differences, then squares and
// normalization), eight core stages of two rotations and up to three
// square root steps each, and the output register. Throughput is one request
// per cycle while out_stall is low; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling; in_stall rises only when every stage is
// full. Empty stages close up, so a stall loses and repeats nothing.
// Reset clears all valid bits; the first request may follow at once.
// ----------------------------------------------------------------------------
module point_distance_and_bearing
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_y,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [pdb_pkg::OUT_W-1:0]              distance,
    output logic [pdb_pkg::OUT_W-1:0]              bearing,
    output logic                                   angle_invalid
);
    import pdb_pkg::*;

    logic      in_ready;
    logic      front_valid;
    logic      core_ready;
    pdb_work_t front_work;
    logic      core_valid;
    logic      back_ready;
    pdb_work_t core_work;

    assign in_stall = !in_ready;

    pdb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ref_x     (ref_x),
        .ref_y     (ref_y),
        .target_x  (target_x),
        .target_y  (target_y),
        .out_valid (front_valid),
        .out_ready (core_ready),
        .out_work  (front_work)
    );

    pdb_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (core_ready),
        .in_work   (front_work),
        .out_valid (core_valid),
        .out_ready (back_ready),
        .out_work  (core_work)
    );

    pdb_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (core_valid),
        .in_ready      (back_ready),
        .in_work       (core_work),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .distance      (distance),
        .bearing       (bearing),
        .angle_invalid (angle_invalid)
    );

    // The input can only be held off when the output is full and stalled.
    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output register can take data");

    // Coincident points give no bearing and zero distance.
    a_invalid_bearing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && angle_invalid) |-> (bearing == '0 && distance == '0))
        else $error("invalid angle with nonzero bearing or distance");

    // The bearing never leaves the half turn around 180 degrees plus the axes.
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bearing <= (OUT_W'(280) << ANGLE_FRAC_BITS)))
        else $error("bearing out of range");

    // An empty output register never holds off the input.
    a_empty_output_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("pipeline blocked with an empty output register");

endmodule

@@ bench/point_distance_and_bearing_checker.sv @@
// ----------------------------------------------------------------------------
// point_distance_and_bearing_checker
// Watches both channels of the distance and bearing block. It predicts each
// result from the accepted request and compares it with what comes out.
// ----------------------------------------------------------------------------
module point_distance_and_bearing_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] ref_y,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_x,
    input  logic signed [pdb_pkg::COORD_WIDTH-1:0] target_y,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [pdb_pkg::OUT_W-1:0]              distance,
    input  logic [pdb_pkg::OUT_W-1:0]              bearing,
    input  logic                                   angle_invalid,
    output int                                     error_count,
    output int                                     pending
);
    import pdb_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] length;
        logic [OUT_W-1:0] bear;
        logic             inv;
    } polar_t;

    polar_t polar_q[$];

    function automatic longint atan_step_deg(input int i);
        longint tab[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115};
        return tab[i];
    endfunction

    function automatic polar_t predict_polar(input logic signed [15:0] rx,
        input logic signed [15:0] ry, input logic signed [15:0] tx,
        input logic signed [15:0] ty);
        polar_t r;
        longint dx, dy, ax, ay, x, y, z, xs, ys, b24;
        logic [63:0] sum, rem, root, trial, m, ux, uy;
        dx = longint'(rx) - longint'(tx);
        dy = longint'(ry) - longint'(ty);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sum = ax * ax + ay * ay;
        rem = 0;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            rem = (rem << 2) | ((sum >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        r.length = root[OUT_W-1:0];
        r.inv = 1'b0;
        b24 = 0;
        if (dx == 0 && dy == 0)
            r.inv = 1'b1;
        else if (dx == 0)
            b24 = (dy > 0 ? 90 : 270) << ACC_FRAC;
        else if (dy == 0)
            b24 = 180 << ACC_FRAC;
        else
        begin
            ux = ax;
            uy = ay;
            m = ux > uy ? ux : uy;
            while (m < (64'd1 << 30))
            begin
                ux = ux << 1; uy = uy << 1; m = m << 1;
            end
            x = ux;
            y = uy;
            z = 0;
            for (int i = 0; i < CORDIC_ITERATIONS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + atan_step_deg(i);
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - atan_step_deg(i);
                end
            end
            if ((dx < 0) != (dy < 0))
                z = -z;
            b24 = (longint'(180) << ACC_FRAC) - z;
            if (b24 < 0)
                b24 = 0;
        end
        // Axis cases are exact and need no rounding term.
        if (r.inv)
            r.bear = '0;
        else if (dx == 0 || dy == 0)
            r.bear = OUT_W'(b24 >> ROUND_SHIFT);
        else
            r.bear = OUT_W'((b24 + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
        return r;
    endfunction

    assign pending = polar_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        polar_t e;
        int diff;
        int errs;
        errs = 0;
        if (!rst_n)
            error_count <= 0;
        else
        begin
            if (in_valid && !in_stall)
                polar_q.push_back(predict_polar(ref_x, ref_y, target_x, target_y));
            if (out_valid && !out_stall)
            begin
                if (polar_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: distance %0d bearing %0d",
                             $time, distance, bearing);
                    errs++;
                end
                else
                begin
                    e = polar_q.pop_front();
                    diff = int'(bearing) - int'(e.bear);
                    if (distance !== e.length)
                    begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, e.length, distance);
                        errs++;
                    end
                    // The bearing may be off by one step of rounding.
                    if ($isunknown(bearing) || diff > 1 || diff < -1)
                    begin
                        $display("%0t: bearing expected %0d actual %0d",
                                 $time, e.bear, bearing);
                        errs++;
                    end
                    if (angle_invalid !== e.inv)
                    begin
                        $display("%0t: angle_invalid expected %0d actual %0d",
                                 $time, e.inv, angle_invalid);
                        errs++;
                    end
                end
            end
            error_count <= error_count + errs;
        end
    end

endmodule

@@ bench/point_distance_and_bearing_tb.sv @@
// ----------------------------------------------------------------------------
// point_distance_and_bearing_tb
// Sends directed and random point pairs through the block with random idle
// cycles on both sides and one long output hold-off; the checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module point_distance_and_bearing_tb;
    import pdb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 500;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic out_valid;
    logic out_stall;
    logic [OUT_W-1:0] distance;
    logic [OUT_W-1:0] bearing;
    logic angle_invalid;
    int error_count;
    int pending;
    int sent_count;
    bit quiet;
    int cycle_count;

    point_distance_and_bearing DUT (.*);

    point_distance_and_bearing_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Presents one request and holds it until it is taken.
    task automatic send_points(input logic signed [15:0] rx, input logic signed [15:0] ry,
                               input logic signed [15:0] tx, input logic signed [15:0] ty);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ref_x <= rx;
        ref_y <= ry;
        target_x <= tx;
        target_y <= ty;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    // Output side: random stalls, one long hold once traffic is flowing.
    initial
    begin
        out_stall = 1'b0;
        wait (sent_count >= 100);
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        forever
        begin
            out_stall <= !quiet && $urandom_range(99) < 6;
            @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("point_distance_and_bearing_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [15:0] rx, ry, tx, ty;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ref_x = '0;
        ref_y = '0;
        target_x = '0;
        target_y = '0;
        sent_count = 0;
        quiet = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_points(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
        send_points(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
        send_points(16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
        send_points(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000);
        send_points(0, 0, 0, 0);
        send_points(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
        send_points(5, 100, 5, -3);
        send_points(5, -100, 5, 3);
        send_points(16'sh7fff, 0, -16'sh8000, 0);
        send_points(-16'sh8000, 0, 16'sh7fff, 0);
        send_points(0, 16'sh7fff, 0, -16'sh8000);
        send_points(0, -16'sh8000, 0, 16'sh7fff);
        send_points(1, 1, 0, 0);
        send_points(-1, 1, 0, 0);
        send_points(-1, -1, 0, 0);
        send_points(1, -1, 0, 0);
        send_points(1, 0, 0, 0);
        send_points(0, 1, 0, 0);
        send_points(1000, 1, 0, 0);
        send_points(1, 1000, 0, 0);
        send_points(-16'sh5555, 16'sh2aaa, 16'sh1234, -16'sh4321);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            quiet = n >= 250 && n < 350;
            rx = 16'($urandom);
            ry = 16'($urandom);
            kind = $urandom_range(9);
            if (kind < 5)
            begin
                tx = 16'($urandom);
                ty = 16'($urandom);
            end
            else if (kind < 7)
            begin
                tx = rx + $signed(16'($urandom_range(64))) - 16'sd32;
                ty = ry + $signed(16'($urandom_range(64))) - 16'sd32;
            end
            else if (kind == 7)
            begin
                tx = rx;
                ty = 16'($urandom);
            end
            else if (kind == 8)
            begin
                tx = 16'($urandom);
                ty = ry;
            end
            else
            begin
                tx = rx;
                ty = ($urandom_range(3) == 0) ? ry : ry + 16'sd1;
            end
            send_points(rx, ry, tx, ty);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("point_distance_and_bearing_tb: clean");
        else
            $display("point_distance_and_bearing_tb: errors");
        $finish;
    end

endmodule

@@ point_distance_and_bearing.f @@
hw/rtl/pdb_pkg.sv
hw/rtl/pdb_front.sv
hw/rtl/pdb_core.sv
hw/rtl/pdb_back.sv
hw/rtl/point_distance_and_bearing.sv
bench/point_distance_and_bearing_checker.sv
bench/point_distance_and_bearing_tb.sv
